// ===== design/assert_macros.svh =====
// Assertion macros shared by the block mean pixelate modules.
// Expects signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define BMP_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define BMP_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/bmp_pkg.sv =====
// Package for block_mean_pixelate: constants, register indexes, queue word and back FSM types.
// No dependencies.
`timescale 1ns / 1ps

package bmp_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_BLOCK_DEF = 64;

   localparam int PIX_W      = 8;
   localparam int MEAN_W     = 8;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int BS_W       = 7;
   localparam int IDX_W      = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd512;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd512;
   localparam logic [BS_W-1:0]  BLOCK_RESET  = 7'd8;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] brow;
      logic               load;
      logic               emit;
      logic               err;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ACC,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage

// ===== design/block_mean_pixelate.sv =====
// Block mean pixelate: one result per completed block, or one error word per bad-size frame.
// Each pixel takes a column sum memory read, then a write; a block result adds the
// 8-step mean divider plus the result load, which waits while an unaccepted result is held.
// Reset, and every write to a known register, runs a size check with req_ready low.
// Column sums are not cleared; each block's sum is loaded by its first pixel.
// Depends on bmp_pkg, bmp_front, bmp_fifo, bmp_back.
`timescale 1ns / 1ps

module block_mean_pixelate #(
   parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [bmp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bmp_pkg::PIX_W-1:0]      req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bmp_pkg::MEAN_W-1:0]     rsp_block_mean,
   output logic [bmp_pkg::COORD_W-1:0]    rsp_block_row,
   output logic [bmp_pkg::COORD_W-1:0]    rsp_block_col,
   output logic                           rsp_frame_end,
   output logic                           rsp_size_error
);

   localparam int BS_MAX = (MAX_BLOCK < 127) ? MAX_BLOCK : 127;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int SQ_W   = $clog2(BS_MAX * BS_MAX + 1);
   localparam int SUM_W  = $clog2(BS_MAX * BS_MAX * 255 + 1);

   bmp_pkg::fifo_stat_type fifo_stat;
   bmp_pkg::entry_type     push_data, head;
   logic                   push, pop;
   logic [SQ_W-1:0]        bs_sq;

   bmp_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK),
      .AW        (AW),
      .SQ_W      (SQ_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_data (push_data),
      .bs_sq     (bs_sq)
   );

   bmp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (fifo_stat)
   );

   bmp_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW),
      .SQ_W      (SQ_W),
      .SUM_W     (SUM_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .fifo_stat      (fifo_stat),
      .pop            (pop),
      .bs_sq          (bs_sq),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_block_mean (rsp_block_mean),
      .rsp_block_row  (rsp_block_row),
      .rsp_block_col  (rsp_block_col),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_size_error (rsp_size_error)
   );

endmodule

// ===== design/bmp_front.sv =====
// Front end: config registers, divisibility check, raster counters, word classification.
// Depends on bmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_front #(
   parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEF,
   parameter int AW        = 12,
   parameter int SQ_W      = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [bmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bmp_pkg::PIX_W-1:0]       req_pixel,
   input  bmp_pkg::fifo_stat_type          fifo_stat,
   output logic                            push,
   output bmp_pkg::entry_type              push_data,
   output logic [SQ_W-1:0]                 bs_sq
);

   logic [bmp_pkg::DIM_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [bmp_pkg::BS_W-1:0]    bsize_ff, bsize_in;
   logic [bmp_pkg::DIM_W-1:0]   w_c, h_c;
   logic [bmp_pkg::BS_W-1:0]    bs_c, bs_m1;

   logic                        chk_busy_ff, chk_busy_in;
   logic [3:0]                  chk_step_ff, chk_step_in;
   logic [bmp_pkg::BS_W-1:0]    rem_w_ff, rem_w_in, rem_h_ff, rem_h_in;
   logic                        bad_ff, bad_in;
   logic [SQ_W-1:0]             bs_sq_ff;

   logic [bmp_pkg::DIM_W-1:0]   pixel_x_ff, pixel_x_in;
   logic [bmp_pkg::COORD_W-1:0] pixel_y_ff, pixel_y_in;
   logic [bmp_pkg::BS_W-1:0]    row_ib_ff, row_ib_in, col_ib_ff, col_ib_in;
   logic [AW-1:0]               block_x_ff, block_x_in;
   logic [bmp_pkg::COORD_W-1:0] block_y_ff, block_y_in;

   logic                        accept, last_col, last_row, frame_last, cfg_hit;
   logic [bmp_pkg::BS_W:0]      sh_w, sh_h;

   always_comb begin
      w_c = width_ff;
      if (width_ff == '0) w_c = bmp_pkg::DIM_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) w_c = bmp_pkg::DIM_W'(MAX_WIDTH);
      h_c = height_ff;
      if (height_ff == '0) h_c = bmp_pkg::DIM_W'(1);
      else if (int'(height_ff) > bmp_pkg::HEIGHT_LIMIT) h_c = bmp_pkg::DIM_W'(bmp_pkg::HEIGHT_LIMIT);
      bs_c = bsize_ff;
      if (bsize_ff == '0) bs_c = bmp_pkg::BS_W'(1);
      else if (int'(bsize_ff) > MAX_BLOCK) bs_c = bmp_pkg::BS_W'(MAX_BLOCK);
      bs_m1 = bs_c - bmp_pkg::BS_W'(1);
   end

   assign req_ready  = !chk_busy_ff && !fifo_stat.full;
   assign accept     = req_valid && req_ready;
   assign last_col   = pixel_x_ff >= (w_c - bmp_pkg::DIM_W'(1));
   assign last_row   = {1'b0, pixel_y_ff} >= (h_c - bmp_pkg::DIM_W'(1));
   assign frame_last = last_col && last_row;
   assign bs_sq      = bs_sq_ff;

   always_comb begin
      push_data       = '0;
      push_data.pixel = req_pixel;
      push_data.last  = frame_last;
      if (bad_ff) begin
         push_data.err = 1'b1;
         push       = accept && frame_last;
      end else begin
         push_data.idx  = bmp_pkg::IDX_W'(block_x_ff);
         push_data.brow = block_y_ff;
         push_data.load = (row_ib_ff == '0) && (col_ib_ff == '0);
         push_data.emit = (row_ib_ff >= bs_m1) && (col_ib_ff >= bs_m1);
         push       = accept;
      end
   end

   // restoring remainder of width and height by block size, one bit per cycle
   always_comb begin
      sh_w = {rem_w_ff, w_c[chk_step_ff]};
      sh_h = {rem_h_ff, h_c[chk_step_ff]};
      rem_w_in = (sh_w >= {1'b0, bs_c}) ? bmp_pkg::BS_W'(sh_w - {1'b0, bs_c})
                                        : bmp_pkg::BS_W'(sh_w);
      rem_h_in = (sh_h >= {1'b0, bs_c}) ? bmp_pkg::BS_W'(sh_h - {1'b0, bs_c})
                                        : bmp_pkg::BS_W'(sh_h);
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      bsize_in    = bsize_ff;
      cfg_hit     = 1'b0;
      chk_busy_in = chk_busy_ff;
      chk_step_in = chk_step_ff;
      bad_in      = bad_ff;
      pixel_x_in  = pixel_x_ff;
      pixel_y_in  = pixel_y_ff;
      row_ib_in   = row_ib_ff;
      col_ib_in   = col_ib_ff;
      block_x_in  = block_x_ff;
      block_y_in  = block_y_ff;

      if (chk_busy_ff) begin
         chk_step_in = chk_step_ff - 4'd1;
         if (chk_step_ff == 4'd0) begin
            chk_busy_in = 1'b0;
            bad_in      = (rem_w_in != '0) || (rem_h_in != '0);
         end
      end

      if (accept) begin
         if (last_col) begin
            pixel_x_in = '0;
            col_ib_in  = '0;
            block_x_in = '0;
            if (last_row) begin
               pixel_y_in = '0;
               row_ib_in  = '0;
               block_y_in = '0;
            end else begin
               pixel_y_in = pixel_y_ff + bmp_pkg::COORD_W'(1);
               if (row_ib_ff >= bs_m1) begin
                  row_ib_in  = '0;
                  block_y_in = block_y_ff + bmp_pkg::COORD_W'(1);
               end else begin
                  row_ib_in = row_ib_ff + bmp_pkg::BS_W'(1);
               end
            end
         end else begin
            pixel_x_in = pixel_x_ff + bmp_pkg::DIM_W'(1);
            if (col_ib_ff >= bs_m1) begin
               col_ib_in  = '0;
               block_x_in = block_x_ff + AW'(1);
            end else begin
               col_ib_in = col_ib_ff + bmp_pkg::BS_W'(1);
            end
         end
      end

      if (csr_write) begin
         case (csr_index)
            bmp_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            bmp_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               cfg_hit   = 1'b1;
            end
            bmp_pkg::REG_BLOCK_SIZE: begin
               bsize_in = csr_wdata[bmp_pkg::BS_W-1:0];
               cfg_hit  = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end

      if (cfg_hit) begin
         chk_busy_in = 1'b1;
         chk_step_in = 4'(bmp_pkg::DIM_W - 1);
         pixel_x_in  = '0;
         pixel_y_in  = '0;
         row_ib_in   = '0;
         col_ib_in   = '0;
         block_x_in  = '0;
         block_y_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= bmp_pkg::WIDTH_RESET;
         height_ff   <= bmp_pkg::HEIGHT_RESET;
         bsize_ff    <= bmp_pkg::BLOCK_RESET;
         chk_busy_ff <= 1'b1;
         chk_step_ff <= 4'(bmp_pkg::DIM_W - 1);
         rem_w_ff    <= '0;
         rem_h_ff    <= '0;
         bad_ff      <= 1'b0;
         pixel_x_ff  <= '0;
         pixel_y_ff  <= '0;
         row_ib_ff   <= '0;
         col_ib_ff   <= '0;
         block_x_ff  <= '0;
         block_y_ff  <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         bsize_ff    <= bsize_in;
         chk_busy_ff <= chk_busy_in;
         chk_step_ff <= chk_step_in;
         if (cfg_hit) begin
            rem_w_ff <= '0;
            rem_h_ff <= '0;
         end else if (chk_busy_ff) begin
            rem_w_ff <= rem_w_in;
            rem_h_ff <= rem_h_in;
         end
         bad_ff      <= bad_in;
         pixel_x_ff  <= pixel_x_in;
         pixel_y_ff  <= pixel_y_in;
         row_ib_ff   <= row_ib_in;
         col_ib_ff   <= col_ib_in;
         block_x_ff  <= block_x_in;
         block_y_ff  <= block_y_in;
      end
   end

   always_ff @(posedge clock) begin
      bs_sq_ff <= SQ_W'(bs_c * bs_c);
   end

   `BMP_ASSERT(a_no_accept_in_check, !(chk_busy_ff && accept), "word taken during size check")

endmodule

// ===== design/bmp_fifo.sv =====
// Short queue of classified words between front and back.
// Depends on bmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bmp_pkg::entry_type     push_data,
   input  logic                   pop,
   output bmp_pkg::entry_type     head,
   output bmp_pkg::fifo_stat_type stat
);

   bmp_pkg::entry_type            slots_ff [bmp_pkg::FIFO_DEPTH];
   logic [bmp_pkg::FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [bmp_pkg::FIFO_AW:0]     count_ff;

   assign head       = slots_ff[rd_ptr_ff];
   assign stat.full  = count_ff == (bmp_pkg::FIFO_AW + 1)'(bmp_pkg::FIFO_DEPTH);
   assign stat.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + bmp_pkg::FIFO_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + bmp_pkg::FIFO_AW'(1);
         if (push && !pop)      count_ff <= count_ff + (bmp_pkg::FIFO_AW + 1)'(1);
         else if (pop && !push) count_ff <= count_ff - (bmp_pkg::FIFO_AW + 1)'(1);
      end
   end

   `BMP_ASSERT(a_no_overflow, !(push && stat.full && !pop), "push into full queue")
   `BMP_ASSERT(a_no_underflow, !(pop && stat.empty), "pop from empty queue")

endmodule

// ===== design/bmp_back.sv =====
// Back end: column sum memory read-modify-write, serial mean divider, result register.
// Depends on bmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_back #(
   parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEF,
   parameter int AW        = 12,
   parameter int SQ_W      = 13,
   parameter int SUM_W     = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bmp_pkg::entry_type             head,
   input  bmp_pkg::fifo_stat_type         fifo_stat,
   output logic                           pop,
   input  logic [SQ_W-1:0]                bs_sq,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bmp_pkg::MEAN_W-1:0]     rsp_block_mean,
   output logic [bmp_pkg::COORD_W-1:0]    rsp_block_row,
   output logic [bmp_pkg::COORD_W-1:0]    rsp_block_col,
   output logic                           rsp_frame_end,
   output logic                           rsp_size_error
);

   localparam int CMP_W = SQ_W + bmp_pkg::MEAN_W;
   localparam int CNT_W = $clog2(bmp_pkg::MEAN_W);

   bmp_pkg::back_state_type state_ff, state_in;
   bmp_pkg::entry_type      cur_ff;

   logic [SUM_W-1:0]              sums [MAX_WIDTH];
   logic [SUM_W-1:0]              rd_ff, sum_c;
   logic [SUM_W-1:0]              rem_ff;
   logic [CMP_W-1:0]              dsh_ff;
   logic [bmp_pkg::MEAN_W-1:0]    q_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          ge, mem_we, out_load;

   logic                          rsp_valid_ff;
   logic [bmp_pkg::MEAN_W-1:0]    mean_ff;
   logic [bmp_pkg::COORD_W-1:0]   row_ff, col_ff;
   logic                          fe_ff, err_ff;

   assign sum_c = cur_ff.load ? SUM_W'(cur_ff.pixel) : rd_ff + SUM_W'(cur_ff.pixel);
   assign ge    = CMP_W'(rem_ff) >= dsh_ff;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      mem_we   = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         bmp_pkg::B_IDLE: begin
            if (!fifo_stat.empty) begin
               pop      = 1'b1;
               state_in = head.err ? bmp_pkg::B_OUT : bmp_pkg::B_ACC;
            end
         end
         bmp_pkg::B_ACC: begin
            mem_we   = 1'b1;
            state_in = cur_ff.emit ? bmp_pkg::B_DIV : bmp_pkg::B_IDLE;
         end
         bmp_pkg::B_DIV: begin
            if (cnt_ff == '0) state_in = bmp_pkg::B_OUT;
         end
         bmp_pkg::B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = bmp_pkg::B_IDLE;
            end
         end
         default: state_in = bmp_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) sums[cur_ff.idx[AW-1:0]] <= sum_c;
      rd_ff <= sums[head.idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
      if (state_ff == bmp_pkg::B_ACC) begin
         rem_ff <= sum_c;
         dsh_ff <= CMP_W'(bs_sq) << (bmp_pkg::MEAN_W - 1);
         q_ff   <= '0;
         cnt_ff <= CNT_W'(bmp_pkg::MEAN_W - 1);
      end else if (state_ff == bmp_pkg::B_DIV) begin
         if (ge) rem_ff <= SUM_W'(CMP_W'(rem_ff) - dsh_ff);
         q_ff   <= {q_ff[bmp_pkg::MEAN_W-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (out_load) begin
         mean_ff <= cur_ff.err ? '0 : q_ff;
         row_ff  <= cur_ff.brow;
         col_ff  <= bmp_pkg::COORD_W'(cur_ff.idx[AW-1:0]);
         fe_ff   <= cur_ff.last;
         err_ff  <= cur_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmp_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_mean = mean_ff;
   assign rsp_block_row  = row_ff;
   assign rsp_block_col  = col_ff;
   assign rsp_frame_end  = fe_ff;
   assign rsp_size_error = err_ff;

   `BMP_ASSERT_NEXT(a_acc_after_pop, pop && !head.err, state_ff == bmp_pkg::B_ACC, "no accumulate after pop")

endmodule
